// ===== hw/rtl/mpm_pkg.sv =====
// Shared constants, codes and types for the modular polynomial multiplier.
// Depends on nothing; every other file but mpm_ram uses it.
package mpm_pkg;

   // Sequence storage.
   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;

   // Field widths.
   localparam int KIND_W  = 2;
   localparam int COEF_IN_W = 32;
   localparam int INDEX_W = 11;
   localparam int COEF_W  = 30;
   localparam int MOD_W   = 31;
   localparam int CSR_IDX_W = 1;

   // Modulus handling.
   localparam logic [MOD_W-1:0] MOD_CAP   = MOD_W'(1 << 30);
   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

   typedef logic [MOD_W-1:0] logic_mod_type;

   // Multiplier split into two half-width partial products.
   localparam int HALF_W = 15;
   localparam logic [HALF_W-1:0] HALF_MASK = HALF_W'((1 << 15) - 1);
   localparam int PP_W = COEF_W + HALF_W;

   // Dividend width of the shared remainder unit: accumulator plus product.
   localparam int SUM_W  = 2 * COEF_W + 1;
   localparam int STEP_W = $clog2(SUM_W);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE  = 1'd1;

   // Remainder unit handshake.
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] value;
   } red_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [COEF_W-1:0] rem;
   } red_rsp_type;

endpackage

// ===== hw/rtl/mpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mpm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/mpm_modred.sv =====
// Sign fold for loaded coefficients: turns the remainder of |x| into x mod m.
// Depends on mpm_pkg.
module mpm_modred (
   input  mpm_pkg::logic_mod_type       modulus,
   input  logic                         neg,
   input  logic [mpm_pkg::COEF_W-1:0]   rem,
   output logic [mpm_pkg::COEF_W-1:0]   value
);
   import mpm_pkg::*;

   // A negative coefficient with a nonzero remainder folds back to m - rem.
   assign value = (neg && rem != '0) ? COEF_W'(modulus - MOD_W'(rem)) : rem;

endmodule

// ===== hw/rtl/mpm_reduce.sv =====
// Bit-serial remainder unit: value mod m, one dividend bit per cycle.
// Depends on mpm_pkg.
module mpm_reduce (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [mpm_pkg::MOD_W-1:0] modulus,
   input  mpm_pkg::red_req_type     req,
   output mpm_pkg::red_rsp_type     rsp
);
   import mpm_pkg::*;

   logic [SUM_W-1:0]  val_ff, val_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_W:0]    trial;

   // One restoring step: shift in the next dividend bit, subtract m if it fits.
   always_comb begin
      trial = {rem_ff, val_ff[SUM_W-1]};
      if (trial >= {1'b0, modulus}) begin
         trial = trial - {1'b0, modulus};
      end
   end

   // Step sequencing.
   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         val_in  = req.value;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SUM_W-2:0], 1'b0};
         rem_in = trial[MOD_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   // The remainder is below m, which is at most 2^30.
   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[COEF_W-1:0];

endmodule

// ===== hw/rtl/modular_polynomial_multiply_top.sv =====
// Top level of the modular polynomial multiplier: control sequencer and storage.
// Depends on mpm_pkg, mpm_ram, mpm_reduce and mpm_modred.
//
// Usage: requests arrive on the req_ valid/ready channel. Kind 0 and 1 append a
// signed coefficient to sequence a or b, reduced into 0..m-1 on the way in;
// kind 3 empties both sequences; kind 2 asks for product coefficient
// read_index and produces exactly one response on the rsp_ channel.
// The csr_ port writes the modulus and square mode; write it only while idle.
// Steps: a clear completes in S_IDLE; an append waits on the bit-serial
// remainder unit. A read works through up to MAX_LEN product terms;
// each term reads a[j] and then its partner coefficient (from b, or from a in
// square mode), splits the multiply into two partial products and then
// reduces the running sum.
// One request is worked on at a time. A finished response sits in an output
// register; while it waits for rsp_ready the block keeps taking appends and
// clears, and a following read stalls only when it has its result ready.
// Reset clears the counts and the response valid flag, sets modulus to
// 1000000007 and square mode off; memory contents are never cleared since
// only entries below the counts are read.
module modular_polynomial_multiply_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mpm_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [mpm_pkg::COEF_IN_W-1:0] req_coeff_in,
   input  logic [mpm_pkg::INDEX_W-1:0]        req_read_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mpm_pkg::COEF_W-1:0]         rsp_product_coeff,
   output logic                               rsp_in_range,
   input  logic                               csr_we,
   input  logic [mpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mpm_pkg::MOD_W-1:0]          csr_wdata
);
   import mpm_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_RDA  = 4'd2;
   localparam logic [3:0] S_RDB  = 4'd3;
   localparam logic [3:0] S_MUL0 = 4'd4;
   localparam logic [3:0] S_MUL1 = 4'd5;
   localparam logic [3:0] S_MUL2 = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [MOD_W-1:0]  modulus_ff;
   logic              square_ff;
   logic [CNT_W-1:0]  a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic              neg_ff, neg_in, to_b_ff, to_b_in;
   logic [CNT_W-1:0]  k_ff, k_in, j_ff, j_in, hi_ff, hi_in;
   logic [COEF_W-1:0] acc_ff, acc_in, op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [PP_W-1:0]   pp_lo_ff, pp_lo_in, pp_hi_ff, pp_hi_in;
   logic              range_ff, range_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0] rsp_coeff_ff, rsp_coeff_in;
   logic              rsp_range_ff, rsp_range_in;

   logic [MOD_W-1:0]     eff_mod;
   logic [COEF_IN_W-1:0] coeff_mag;
   logic [CNT_W-1:0]     k_ext, la, lb, lo;
   logic                 accept;
   red_req_type          red_req;
   red_rsp_type          red_rsp;
   logic [COEF_W-1:0]    load_val;
   logic                 a_we, b_we, a_re, b_re;
   logic [ADDR_W-1:0]    a_raddr, b_raddr, wr_addr;
   logic [COEF_W-1:0]    a_rdata, b_rdata, bs_rdata;
   logic [ADDR_W-1:0]    partner;

   // Effective modulus: zero acts as one, large values saturate.
   always_comb begin
      eff_mod = modulus_ff;
      if (modulus_ff == '0) begin
         eff_mod = MOD_W'(1);
      end else if (modulus_ff > MOD_CAP) begin
         eff_mod = MOD_CAP;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RESET;
         square_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata;
            CSR_SQUARE:  square_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Request decode helpers.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign coeff_mag = req_coeff_in[COEF_IN_W-1] ? COEF_IN_W'(-req_coeff_in)
                                                : COEF_IN_W'(req_coeff_in);
   assign k_ext   = CNT_W'(req_read_index);
   assign la      = a_count_ff;
   assign lb      = square_ff ? a_count_ff : b_count_ff;
   assign lo      = (k_ext >= lb) ? k_ext - (lb - 1'b1) : '0;
   assign partner = ADDR_W'(k_ff - j_ff);

   // Negative coefficients fold back into 0..m-1.
   mpm_modred u_fold (
      .modulus (eff_mod),
      .neg     (neg_ff),
      .rem     (red_rsp.rem),
      .value   (load_val)
   );

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      a_count_in   = a_count_ff;
      b_count_in   = b_count_ff;
      neg_in       = neg_ff;
      to_b_in      = to_b_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      pp_lo_in     = pp_lo_ff;
      pp_hi_in     = pp_hi_ff;
      range_in     = range_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_coeff_in = rsp_coeff_ff;
      rsp_range_in = rsp_range_ff;
      red_req      = '{start: 1'b0, value: SUM_W'(coeff_mag)};
      a_we         = 1'b0;
      b_we         = 1'b0;
      a_re         = 1'b0;
      b_re         = 1'b0;
      a_raddr      = j_ff[ADDR_W-1:0];
      b_raddr      = partner;
      wr_addr      = a_count_ff[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_APPEND_A: begin
                     if (a_count_ff < CNT_W'(MAX_LEN)) begin
                        red_req.start = 1'b1;
                        neg_in   = req_coeff_in[COEF_IN_W-1];
                        to_b_in  = 1'b0;
                        state_in = S_LOAD;
                     end
                  end
                  KIND_APPEND_B: begin
                     if (!square_ff && b_count_ff < CNT_W'(MAX_LEN)) begin
                        red_req.start = 1'b1;
                        neg_in   = req_coeff_in[COEF_IN_W-1];
                        to_b_in  = 1'b1;
                        state_in = S_LOAD;
                     end
                  end
                  KIND_READ: begin
                     k_in     = k_ext;
                     j_in     = lo;
                     hi_in    = (k_ext < la) ? k_ext : la - 1'b1;
                     acc_in   = '0;
                     range_in = ({1'b0, k_ext} + 1'b1) < ({1'b0, la} + {1'b0, lb});
                     if (range_in && la != '0 && lb != '0) begin
                        state_in = S_RDA;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  KIND_CLEAR: begin
                     a_count_in = '0;
                     b_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         // Wait for the reduced coefficient, then store it.
         S_LOAD: begin
            if (red_rsp.done) begin
               if (to_b_ff) begin
                  b_we       = 1'b1;
                  wr_addr    = b_count_ff[ADDR_W-1:0];
                  b_count_in = b_count_ff + 1'b1;
               end else begin
                  a_we       = 1'b1;
                  a_count_in = a_count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         // Read a[j].
         S_RDA: begin
            a_re     = 1'b1;
            state_in = S_RDB;
         end
         // Capture a[j] and read the partner coefficient.
         S_RDB: begin
            op_a_in = a_rdata;
            if (square_ff) begin
               a_re    = 1'b1;
               a_raddr = partner;
            end else begin
               b_re = 1'b1;
            end
            state_in = S_MUL0;
         end
         S_MUL0: begin
            op_b_in  = bs_rdata;
            pp_lo_in = PP_W'(op_a_ff) * PP_W'(bs_rdata[HALF_W-1:0] & HALF_MASK);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            pp_hi_in = PP_W'(op_a_ff) * PP_W'(op_b_ff[COEF_W-1:HALF_W]);
            state_in = S_MUL2;
         end
         // Reduce the running sum plus this product.
         S_MUL2: begin
            red_req.start = 1'b1;
            red_req.value = SUM_W'(acc_ff) + SUM_W'(pp_lo_ff)
                          + (SUM_W'(pp_hi_ff) << HALF_W);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (red_rsp.done) begin
               acc_in = red_rsp.rem;
               if (j_ff == hi_ff) begin
                  state_in = S_FIN;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_RDA;
               end
            end
         end
         // Hand the result to the output register once it is free.
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_coeff_in = range_ff ? acc_ff : '0;
               rsp_range_in = range_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign bs_rdata = square_ff ? a_rdata : b_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_count_ff   <= '0;
         b_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff       <= neg_in;
      to_b_ff      <= to_b_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      hi_ff        <= hi_in;
      acc_ff       <= acc_in;
      op_a_ff      <= op_a_in;
      op_b_ff      <= op_b_in;
      pp_lo_ff     <= pp_lo_in;
      pp_hi_ff     <= pp_hi_in;
      range_ff     <= range_in;
      rsp_coeff_ff <= rsp_coeff_in;
      rsp_range_ff <= rsp_range_in;
   end

   // Shared remainder unit for loads and for the accumulation.
   mpm_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .modulus (eff_mod),
      .req     (red_req),
      .rsp     (red_rsp)
   );

   // Coefficient memories. Writes finish before any later read is issued.
   mpm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (wr_addr),
      .wdata (load_val),
      .re    (a_re),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mpm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (wr_addr),
      .wdata (load_val),
      .re    (b_re),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_coeff = rsp_coeff_ff;
   assign rsp_in_range      = rsp_range_ff;

endmodule

// ===== hw/rtl/mpm_checker.sv =====
// Port-level checks for the modular polynomial multiplier, bound to the top.
// Depends on mpm_pkg.
module mpm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mpm_pkg::COEF_W-1:0]  rsp_product_coeff,
   input logic                        rsp_in_range
);

   // An out-of-range response always carries a zero coefficient.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |-> (rsp_product_coeff == '0))
      else $error("out-of-range response with nonzero coefficient");

   // Reset leaves the block idle with no pending response.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_product_coeff) && $stable(rsp_in_range)))
      else $error("stalled response changed");

endmodule

bind modular_polynomial_multiply_top mpm_checker u_mpm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_product_coeff (rsp_product_coeff),
   .rsp_in_range      (rsp_in_range)
);
